// ----- src/bps_pkg.sv -----
// Shared types, constants and helper functions for the box physics step core.
package bps_pkg;

  localparam int MAX_BOXES_DEF = 16;
  localparam int IDXW          = 4;
  localparam int QW            = 32;
  localparam int OVW           = 36;
  localparam int CNTW          = 5;
  localparam int CFG_IW        = 2;
  localparam int UOPW          = 4;

  localparam logic signed [QW-1:0] GRAVITY_RST = -32'sd642253;
  localparam logic signed [QW-1:0] DT_MAX      = 32'sd3277;
  localparam logic signed [QW-1:0] FLOOR_EPS   = 32'sd131;
  localparam logic signed [QW-1:0] FRICTION    = 32'sd56361;
  localparam logic signed [QW-1:0] REST_LIMIT  = 32'sd1311;
  localparam logic signed [QW-1:0] BOUNCE      = -32'sd19661;

  localparam logic [2:0] FN_WPOS  = 3'd0;
  localparam logic [2:0] FN_WVEL  = 3'd1;
  localparam logic [2:0] FN_WHALF = 3'd2;
  localparam logic [2:0] FN_STEP  = 3'd3;
  localparam logic [2:0] FN_READ  = 3'd4;

  localparam logic [CFG_IW-1:0] CFG_COUNT   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_GRAVITY = 2'd1;

  localparam int WE_POS  = 0;
  localparam int WE_VEL  = 1;
  localparam int WE_HALF = 2;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // integration sequence
  localparam logic [UOPW-1:0] U1_GRAV  = 4'd0;
  localparam logic [UOPW-1:0] U1_MX    = 4'd1;
  localparam logic [UOPW-1:0] U1_AX    = 4'd2;
  localparam logic [UOPW-1:0] U1_MY    = 4'd3;
  localparam logic [UOPW-1:0] U1_AY    = 4'd4;
  localparam logic [UOPW-1:0] U1_MZ    = 4'd5;
  localparam logic [UOPW-1:0] U1_AZ    = 4'd6;
  localparam logic [UOPW-1:0] U1_EPS   = 4'd7;
  localparam logic [UOPW-1:0] U1_FLOOR = 4'd8;
  localparam logic [UOPW-1:0] U1_FRX   = 4'd9;
  localparam logic [UOPW-1:0] U1_FRZ   = 4'd10;

  // pair sequence
  localparam logic [UOPW-1:0] U2_HX  = 4'd0;
  localparam logic [UOPW-1:0] U2_DX  = 4'd1;
  localparam logic [UOPW-1:0] U2_OX  = 4'd2;
  localparam logic [UOPW-1:0] U2_HY  = 4'd3;
  localparam logic [UOPW-1:0] U2_DY  = 4'd4;
  localparam logic [UOPW-1:0] U2_OY  = 4'd5;
  localparam logic [UOPW-1:0] U2_HZ  = 4'd6;
  localparam logic [UOPW-1:0] U2_DZ  = 4'd7;
  localparam logic [UOPW-1:0] U2_OZ  = 4'd8;
  localparam logic [UOPW-1:0] U2_SEL = 4'd9;
  localparam logic [UOPW-1:0] U2_POS = 4'd10;
  localparam logic [UOPW-1:0] U2_VEL = 4'd11;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_ABSD,
    ALU_ADDSAT,
    ALU_QMUL
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_RD_OUT,
    S_GDT,
    S_P1_RD,
    S_P1_LD,
    S_P1_OP,
    S_P1_WB,
    S_P2_RDA,
    S_P2_LDA,
    S_P2_RDB,
    S_P2_LDB,
    S_P2_OP,
    S_P2_WBB,
    S_P2_WBA
  } state_t;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } vec3_t;

  typedef struct packed {
    vec3_t pos;
    vec3_t vel;
    vec3_t half;
  } box_t;

  function automatic logic signed [QW-1:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[QW-1:0];
  endfunction

  function automatic logic signed [OVW-1:0] sx36(logic signed [QW-1:0] v);
    return {{(OVW-QW){v[QW-1]}}, v};
  endfunction

  function automatic logic signed [QW-1:0] snap(logic signed [QW-1:0] v);
    if (v > -REST_LIMIT && v < REST_LIMIT) begin
      return '0;
    end
    return v;
  endfunction

endpackage

// ----- src/bps_alu.sv -----
// Shared arithmetic unit: add, subtract, absolute difference, saturating add, Q16.16 multiply.
module bps_alu import bps_pkg::*; (
  input  alu_op_t                op,
  input  logic signed [OVW-1:0]  a,
  input  logic signed [OVW-1:0]  b,
  output logic signed [OVW-1:0]  res
);

  logic signed [63:0] a64;
  logic signed [63:0] b64;
  logic signed [63:0] sum64;
  logic signed [63:0] diff64;
  logic signed [63:0] prod;
  logic signed [63:0] rnd;

  always_comb begin
    a64    = {{(64-OVW){a[OVW-1]}}, a};
    b64    = {{(64-OVW){b[OVW-1]}}, b};
    sum64  = a64 + b64;
    diff64 = a64 - b64;
    prod   = $signed(a[QW-1:0]) * $signed(b[QW-1:0]);
    rnd    = (prod + 64'sd32768) >>> 16;
    unique case (op)
      ALU_ADD:    res = sum64[OVW-1:0];
      ALU_SUB:    res = diff64[OVW-1:0];
      ALU_ABSD:   res = diff64[63] ? -diff64[OVW-1:0] : diff64[OVW-1:0];
      ALU_ADDSAT: res = sx36(sat32(sum64));
      ALU_QMUL:   res = sx36(sat32(rnd));
      default:    res = '0;
    endcase
  end

endmodule

// ----- src/bps_store.sv -----
// Box table memories: position, velocity and half extents, one write and one registered read port.
module bps_store import bps_pkg::*; #(
  parameter int DEPTH = MAX_BOXES_DEF,
  parameter int AW    = $clog2(MAX_BOXES_DEF)
) (
  input  logic          clk,
  input  logic [2:0]    wr_en,
  input  logic [AW-1:0] waddr,
  input  box_t          wdata,
  input  logic [AW-1:0] raddr,
  output box_t          rdata
);

  vec3_t pos_mem  [DEPTH];
  vec3_t vel_mem  [DEPTH];
  vec3_t half_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en[WE_POS]) begin
      pos_mem[waddr] <= wdata.pos;
    end
    if (wr_en[WE_VEL]) begin
      vel_mem[waddr] <= wdata.vel;
    end
    if (wr_en[WE_HALF]) begin
      half_mem[waddr] <= wdata.half;
    end
    rdata.pos  <= pos_mem[raddr];
    rdata.vel  <= vel_mem[raddr];
    rdata.half <= half_mem[raddr];
  end

endmodule

// ----- src/box_physics_step_core.sv -----
// Top level of the box physics step core: sequencer, working registers and flags.
//
// Usage: items enter on in_valid/in_ready. func 0..2 load position (with the
// dynamic flag), velocity or half extents of one box. func 4 reads one box;
// its result passes through the read wait and read output states into the
// output register and leaves on out_valid/out_ready; it is held back while
// an earlier result is still held. func 3 runs a step: one Q16.16 multiply
// for gravity, then every box in use, then every pair that holds a dynamic
// box (pairs of two static boxes are skipped). The length of a step is set
// by the single shared ALU (one op per cycle) and the one read port of the
// box table. in_ready is low for the whole step.
// Config writes (cfg_valid/cfg_ready, always ready) set object_count and
// gravity; write them only while idle. Synchronous reset clears the flags,
// object_count and the output valid and loads the default gravity; box table
// contents are undefined until written. A stalled receiver holds the read
// result in the output register; writes and steps are still accepted.
module box_physics_step_core import bps_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_func,
  input  logic [IDXW-1:0]      in_box_index,
  input  logic signed [QW-1:0] in_vec_x,
  input  logic signed [QW-1:0] in_vec_y,
  input  logic signed [QW-1:0] in_vec_z,
  input  logic                 in_is_dynamic,
  input  logic signed [QW-1:0] in_time_step,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDXW-1:0]      out_index,
  output logic signed [QW-1:0] out_pos_x,
  output logic signed [QW-1:0] out_pos_y,
  output logic signed [QW-1:0] out_pos_z,
  output logic signed [QW-1:0] out_vel_x,
  output logic signed [QW-1:0] out_vel_y,
  output logic signed [QW-1:0] out_vel_z,
  output logic                 out_dynamic,
  output logic                 out_grounded,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IW-1:0]    cfg_index,
  input  logic [QW-1:0]        cfg_data
);

  localparam int AW   = $clog2(MAX_BOXES);
  localparam int NW   = $clog2(MAX_BOXES + 1);
  localparam int CMPW = NW + CNTW;
  localparam int IXW  = IDXW + NW;

  state_t state_r, state_nxt;
  logic [UOPW-1:0] uop_r;
  logic [NW-1:0]   i_r, j_r, n_r;
  logic [AW-1:0]   ia, ja;

  logic [CNTW-1:0]       cnt_r;
  logic signed [QW-1:0]  grav_r;
  logic signed [QW-1:0]  dtc_r;
  logic signed [QW-1:0]  gdt_r;
  logic [MAX_BOXES-1:0]  dyn_r;
  logic [MAX_BOXES-1:0]  gnd_r;

  // working copies of box a (outer) and box b (inner)
  logic signed [QW-1:0]  pa_r [3];
  logic signed [QW-1:0]  va_r [3];
  logic signed [QW-1:0]  ha_r [3];
  logic signed [QW-1:0]  pb_r [3];
  logic signed [QW-1:0]  vb_r [3];
  logic signed [QW-1:0]  hb_r [3];
  logic signed [OVW-1:0] ov_r [3];
  logic signed [OVW-1:0] tmp_r;
  logic                  da_r, db_r, dir_r;
  logic [1:0]            ax_r;

  logic [AW-1:0]   rd_addr_r;
  logic [IDXW-1:0] rd_idx_r;
  logic            rd_in_r;

  logic                 out_valid_r;
  logic [IDXW-1:0]      out_index_r;
  logic signed [QW-1:0] out_px_r, out_py_r, out_pz_r, out_vx_r, out_vy_r, out_vz_r;
  logic                 out_dyn_r, out_gnd_r;

  // input decode
  logic [IXW-1:0]  idx_w;
  logic            in_inside;
  logic [AW-1:0]   in_addr;
  logic [CMPW-1:0] cnt_w;
  logic [NW-1:0]   n_lim;
  logic            accept;

  // sequencer outputs
  alu_op_t               alu_op;
  logic signed [OVW-1:0] alu_a, alu_b, alu_res;
  logic [2:0]            st_we;
  logic [AW-1:0]         st_waddr, st_raddr;
  box_t                  st_wdata, st_rdata, box_a, box_b, box_in;

  // pair decision
  logic                  overlap;
  logic [1:0]            sel_ax;
  logic                  sel_dir;
  logic                  both_dyn;
  logic signed [OVW-1:0] o_sel, h_sel, o_dir, h_dir;
  logic                  floor_hit;

  assign idx_w     = IXW'(in_box_index);
  assign in_inside = idx_w < IXW'(MAX_BOXES);
  assign in_addr   = idx_w[AW-1:0];
  assign cnt_w     = CMPW'(cnt_r);
  assign n_lim     = (cnt_w > CMPW'(MAX_BOXES)) ? NW'(MAX_BOXES) : cnt_w[NW-1:0];
  assign ia        = i_r[AW-1:0];
  assign ja        = j_r[AW-1:0];
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign box_in.pos  = '{x: in_vec_x, y: in_vec_y, z: in_vec_z};
  assign box_in.vel  = box_in.pos;
  assign box_in.half = box_in.pos;
  assign box_a.pos   = '{x: pa_r[0], y: pa_r[1], z: pa_r[2]};
  assign box_a.vel   = '{x: va_r[0], y: va_r[1], z: va_r[2]};
  assign box_a.half  = '{x: ha_r[0], y: ha_r[1], z: ha_r[2]};
  assign box_b.pos   = '{x: pb_r[0], y: pb_r[1], z: pb_r[2]};
  assign box_b.vel   = '{x: vb_r[0], y: vb_r[1], z: vb_r[2]};
  assign box_b.half  = '{x: hb_r[0], y: hb_r[1], z: hb_r[2]};

  // pick the axis of least penetration
  assign overlap   = (ov_r[0] > 0) && (ov_r[1] > 0) && (ov_r[2] > 0);
  assign sel_ax    = (ov_r[0] < ov_r[1] && ov_r[0] < ov_r[2]) ? AX_X :
                     (ov_r[1] < ov_r[2]) ? AX_Y : AX_Z;
  assign sel_dir   = pa_r[sel_ax] >= pb_r[sel_ax];
  assign both_dyn  = da_r && db_r;
  assign o_sel     = ov_r[ax_r];
  assign h_sel     = o_sel >>> 1;
  assign o_dir     = dir_r ? o_sel : -o_sel;
  assign h_dir     = dir_r ? h_sel : -h_sel;
  assign floor_hit = pa_r[1] <= $signed(tmp_r[QW-1:0]);

  bps_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  bps_store #(
    .DEPTH (MAX_BOXES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .wr_en (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state, ALU operands and table port control
  always_comb begin
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    alu_op    = ALU_ADD;
    alu_a     = '0;
    alu_b     = '0;
    st_we     = '0;
    st_waddr  = ia;
    st_wdata  = box_a;
    st_raddr  = ia;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          st_waddr = in_addr;
          st_wdata = box_in;
          case (in_func)
            FN_WPOS:  st_we[WE_POS]  = in_inside;
            FN_WVEL:  st_we[WE_VEL]  = in_inside;
            FN_WHALF: st_we[WE_HALF] = in_inside;
            FN_STEP:  state_nxt = S_GDT;
            FN_READ:  state_nxt = S_RD_WAIT;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD_WAIT: begin
        st_raddr  = rd_addr_r;
        state_nxt = S_RD_OUT;
      end
      S_RD_OUT: begin
        st_raddr = rd_addr_r;
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_GDT: begin
        alu_op    = ALU_QMUL;
        alu_a     = sx36(grav_r);
        alu_b     = sx36(dtc_r);
        state_nxt = S_P1_RD;
      end
      S_P1_RD: begin
        state_nxt = (i_r == n_r) ? S_P2_RDA : S_P1_LD;
      end
      S_P1_LD: begin
        state_nxt = dyn_r[ia] ? S_P1_OP : S_P1_RD;
      end
      S_P1_OP: begin
        case (uop_r)
          U1_GRAV: begin
            alu_op = ALU_ADDSAT; alu_a = sx36(va_r[1]); alu_b = sx36(gdt_r);
          end
          U1_MX: begin
            alu_op = ALU_QMUL; alu_a = sx36(va_r[0]); alu_b = sx36(dtc_r);
          end
          U1_AX: begin
            alu_op = ALU_ADDSAT; alu_a = sx36(pa_r[0]); alu_b = tmp_r;
          end
          U1_MY: begin
            alu_op = ALU_QMUL; alu_a = sx36(va_r[1]); alu_b = sx36(dtc_r);
          end
          U1_AY: begin
            alu_op = ALU_ADDSAT; alu_a = sx36(pa_r[1]); alu_b = tmp_r;
          end
          U1_MZ: begin
            alu_op = ALU_QMUL; alu_a = sx36(va_r[2]); alu_b = sx36(dtc_r);
          end
          U1_AZ: begin
            alu_op = ALU_ADDSAT; alu_a = sx36(pa_r[2]); alu_b = tmp_r;
          end
          U1_EPS: begin
            alu_op = ALU_ADDSAT; alu_a = sx36(ha_r[1]); alu_b = sx36(FLOOR_EPS);
          end
          U1_FLOOR: begin
            if (!floor_hit) begin
              state_nxt = S_P1_WB;
            end
          end
          U1_FRX: begin
            alu_op = ALU_QMUL; alu_a = sx36(va_r[0]); alu_b = sx36(FRICTION);
          end
          U1_FRZ: begin
            alu_op    = ALU_QMUL; alu_a = sx36(va_r[2]); alu_b = sx36(FRICTION);
            state_nxt = S_P1_WB;
          end
          default: state_nxt = S_P1_WB;
        endcase
      end
      S_P1_WB: begin
        st_we     = 3'b111;
        state_nxt = S_P1_RD;
      end
      S_P2_RDA: begin
        state_nxt = (i_r == n_r) ? S_IDLE : S_P2_LDA;
      end
      S_P2_LDA: begin
        state_nxt = S_P2_RDB;
      end
      S_P2_RDB: begin
        st_raddr = ja;
        if (j_r == n_r) begin
          state_nxt = S_P2_WBA;
        end else if (da_r || dyn_r[ja]) begin
          state_nxt = S_P2_LDB;
        end
      end
      S_P2_LDB: begin
        st_raddr  = ja;
        state_nxt = S_P2_OP;
      end
      S_P2_OP: begin
        case (uop_r)
          U2_HX: begin alu_op = ALU_ADD;  alu_a = sx36(ha_r[0]); alu_b = sx36(hb_r[0]); end
          U2_DX: begin alu_op = ALU_ABSD; alu_a = sx36(pa_r[0]); alu_b = sx36(pb_r[0]); end
          U2_OX: begin alu_op = ALU_SUB;  alu_a = ov_r[0];       alu_b = tmp_r;         end
          U2_HY: begin alu_op = ALU_ADD;  alu_a = sx36(ha_r[1]); alu_b = sx36(hb_r[1]); end
          U2_DY: begin alu_op = ALU_ABSD; alu_a = sx36(pa_r[1]); alu_b = sx36(pb_r[1]); end
          U2_OY: begin alu_op = ALU_SUB;  alu_a = ov_r[1];       alu_b = tmp_r;         end
          U2_HZ: begin alu_op = ALU_ADD;  alu_a = sx36(ha_r[2]); alu_b = sx36(hb_r[2]); end
          U2_DZ: begin alu_op = ALU_ABSD; alu_a = sx36(pa_r[2]); alu_b = sx36(pb_r[2]); end
          U2_OZ: begin alu_op = ALU_SUB;  alu_a = ov_r[2];       alu_b = tmp_r;         end
          U2_SEL: begin
            if (!overlap) begin
              state_nxt = S_P2_RDB;
            end
          end
          U2_POS: begin
            alu_op = ALU_ADDSAT;
            if (both_dyn) begin
              alu_a = sx36(pa_r[ax_r]); alu_b = h_dir;
            end else if (da_r) begin
              alu_a = sx36(pa_r[ax_r]); alu_b = o_dir;
            end else begin
              alu_a = sx36(pb_r[ax_r]); alu_b = -o_dir;
            end
          end
          U2_VEL: begin
            if (both_dyn) begin
              alu_op = ALU_ADDSAT; alu_a = sx36(pb_r[ax_r]); alu_b = -h_dir;
            end else begin
              alu_op = ALU_QMUL;
              alu_a  = da_r ? sx36(va_r[ax_r]) : sx36(vb_r[ax_r]);
              alu_b  = sx36(BOUNCE);
            end
            state_nxt = S_P2_WBB;
          end
          default: state_nxt = S_P2_WBB;
        endcase
      end
      S_P2_WBB: begin
        st_we     = 3'b111;
        st_waddr  = ja;
        st_wdata  = box_b;
        state_nxt = S_P2_RDB;
      end
      S_P2_WBA: begin
        st_we     = 3'b111;
        state_nxt = S_P2_RDA;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      grav_r      <= GRAVITY_RST;
      dyn_r       <= '0;
      gnd_r       <= '0;
      out_valid_r <= 1'b0;
      uop_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      n_r         <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_COUNT:   cnt_r  <= cfg_data[CNTW-1:0];
          CFG_GRAVITY: grav_r <= cfg_data;
          default:     ;
        endcase
      end
      // drop the result once taken; a read in its output state reloads it instead
      if (out_valid_r && out_ready && state_r != S_RD_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_func == FN_WPOS && in_inside) begin
              dyn_r[in_addr] <= in_is_dynamic;
            end
            rd_addr_r <= in_addr;
            rd_idx_r  <= in_box_index;
            rd_in_r   <= in_inside;
            n_r       <= n_lim;
            i_r       <= '0;
            // clamp the step length to 0 .. DT_MAX
            if (in_time_step < 0) begin
              dtc_r <= '0;
            end else if (in_time_step > DT_MAX) begin
              dtc_r <= DT_MAX;
            end else begin
              dtc_r <= in_time_step;
            end
          end
        end
        S_RD_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_index_r <= rd_idx_r;
            out_px_r    <= rd_in_r ? st_rdata.pos.x : '0;
            out_py_r    <= rd_in_r ? st_rdata.pos.y : '0;
            out_pz_r    <= rd_in_r ? st_rdata.pos.z : '0;
            out_vx_r    <= rd_in_r ? st_rdata.vel.x : '0;
            out_vy_r    <= rd_in_r ? st_rdata.vel.y : '0;
            out_vz_r    <= rd_in_r ? st_rdata.vel.z : '0;
            out_dyn_r   <= rd_in_r && dyn_r[rd_addr_r];
            out_gnd_r   <= rd_in_r && gnd_r[rd_addr_r];
          end
        end
        S_GDT: begin
          gdt_r <= alu_res[QW-1:0];
        end
        S_P1_RD: begin
          if (i_r == n_r) begin
            i_r <= '0;
          end
        end
        S_P1_LD: begin
          pa_r <= '{st_rdata.pos.x,  st_rdata.pos.y,  st_rdata.pos.z};
          va_r <= '{st_rdata.vel.x,  st_rdata.vel.y,  st_rdata.vel.z};
          ha_r <= '{st_rdata.half.x, st_rdata.half.y, st_rdata.half.z};
          uop_r <= '0;
          // static boxes count as grounded
          if (!dyn_r[ia]) begin
            gnd_r[ia] <= 1'b1;
            i_r       <= i_r + 1'b1;
          end
        end
        S_P1_OP: begin
          uop_r <= uop_r + 1'b1;
          case (uop_r)
            U1_GRAV: va_r[1] <= alu_res[QW-1:0];
            U1_MX, U1_MY, U1_MZ, U1_EPS: tmp_r <= alu_res;
            U1_AX: pa_r[0] <= alu_res[QW-1:0];
            U1_AY: pa_r[1] <= alu_res[QW-1:0];
            U1_AZ: pa_r[2] <= alu_res[QW-1:0];
            U1_FLOOR: begin
              gnd_r[ia] <= floor_hit;
              if (floor_hit) begin
                pa_r[1] <= ha_r[1];
                if (va_r[1] < 0) begin
                  va_r[1] <= '0;
                end
              end
            end
            U1_FRX: va_r[0] <= snap(alu_res[QW-1:0]);
            U1_FRZ: va_r[2] <= snap(alu_res[QW-1:0]);
            default: ;
          endcase
        end
        S_P1_WB: begin
          i_r <= i_r + 1'b1;
        end
        S_P2_RDA: begin
          j_r <= i_r + 1'b1;
        end
        S_P2_LDA: begin
          pa_r <= '{st_rdata.pos.x,  st_rdata.pos.y,  st_rdata.pos.z};
          va_r <= '{st_rdata.vel.x,  st_rdata.vel.y,  st_rdata.vel.z};
          ha_r <= '{st_rdata.half.x, st_rdata.half.y, st_rdata.half.z};
          da_r <= dyn_r[ia];
        end
        S_P2_RDB: begin
          // skip pairs of two static boxes
          if (j_r != n_r && !da_r && !dyn_r[ja]) begin
            j_r <= j_r + 1'b1;
          end
        end
        S_P2_LDB: begin
          pb_r  <= '{st_rdata.pos.x,  st_rdata.pos.y,  st_rdata.pos.z};
          vb_r  <= '{st_rdata.vel.x,  st_rdata.vel.y,  st_rdata.vel.z};
          hb_r  <= '{st_rdata.half.x, st_rdata.half.y, st_rdata.half.z};
          db_r  <= dyn_r[ja];
          uop_r <= '0;
        end
        S_P2_OP: begin
          uop_r <= uop_r + 1'b1;
          case (uop_r)
            U2_HX, U2_OX: ov_r[0] <= alu_res;
            U2_HY, U2_OY: ov_r[1] <= alu_res;
            U2_HZ, U2_OZ: ov_r[2] <= alu_res;
            U2_DX, U2_DY, U2_DZ: tmp_r <= alu_res;
            U2_SEL: begin
              ax_r  <= sel_ax;
              dir_r <= sel_dir;
              if (!overlap) begin
                j_r <= j_r + 1'b1;
              end
            end
            U2_POS: begin
              if (both_dyn) begin
                pa_r[ax_r] <= alu_res[QW-1:0];
                va_r[ax_r] <= vb_r[ax_r];
                vb_r[ax_r] <= va_r[ax_r];
              end else if (da_r) begin
                pa_r[ax_r] <= alu_res[QW-1:0];
              end else begin
                pb_r[ax_r] <= alu_res[QW-1:0];
              end
            end
            U2_VEL: begin
              if (both_dyn) begin
                pb_r[ax_r] <= alu_res[QW-1:0];
              end else if (da_r) begin
                if (ax_r != AX_Y) begin
                  va_r[ax_r] <= alu_res[QW-1:0];
                end else if (dir_r) begin
                  gnd_r[ia] <= 1'b1;
                  if (va_r[ax_r] < 0) begin
                    va_r[ax_r] <= '0;
                  end
                end else if (va_r[ax_r] > 0) begin
                  va_r[ax_r] <= '0;
                end
              end else begin
                if (ax_r != AX_Y) begin
                  vb_r[ax_r] <= alu_res[QW-1:0];
                end else if (!dir_r) begin
                  gnd_r[ja] <= 1'b1;
                  if (vb_r[ax_r] < 0) begin
                    vb_r[ax_r] <= '0;
                  end
                end
              end
            end
            default: ;
          endcase
        end
        S_P2_WBB: begin
          j_r <= j_r + 1'b1;
        end
        S_P2_WBA: begin
          i_r <= i_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_index    = out_index_r;
  assign out_pos_x    = out_px_r;
  assign out_pos_y    = out_py_r;
  assign out_pos_z    = out_pz_r;
  assign out_vel_x    = out_vx_r;
  assign out_vel_y    = out_vy_r;
  assign out_vel_z    = out_vz_r;
  assign out_dynamic  = out_dyn_r;
  assign out_grounded = out_gnd_r;

  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FN_STEP) |=> !in_ready)
    else $error("input taken during a step");

  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FN_READ) |=> (state_r == S_RD_WAIT) ##1 (state_r == S_RD_OUT))
    else $error("read did not go through the table port");

  a_count_lim: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(MAX_BOXES))
    else $error("box count above table size");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P2_OP) |-> (j_r > i_r && j_r < n_r))
    else $error("pair indexes out of order");

endmodule

// ----- dv/box_physics_step_core_test.sv -----
// Self-checking testbench for the box physics step core with a built-in physics predictor.
`timescale 1ns / 100ps

module box_physics_step_core_test;
  import bps_pkg::*;

  localparam int NBOX      = 16;
  localparam int WDOG_MAX  = 20000;  // cycles with no accepted item of any kind
  localparam int SETTLE    = 3000;   // longest step plus margin
  localparam int HOLD_LONG = 600;    // receiver hold-off for the pressure phase

  typedef struct {
    logic [2:0]  func;
    logic [3:0]  idx;
    logic [31:0] vx, vy, vz;
    logic        dyn;
    logic [31:0] dt;
  } box_cmd_t;

  typedef struct {
    logic [3:0]  idx;
    logic [31:0] px, py, pz, vx, vy, vz;
    logic        dyn, grnd;
  } box_view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        in_func = '0;
  logic [IDXW-1:0]   in_box_index = '0;
  logic [QW-1:0]     in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  logic              in_is_dynamic = 1'b0;
  logic [QW-1:0]     in_time_step = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [IDXW-1:0]   out_index;
  logic [QW-1:0]     out_pos_x, out_pos_y, out_pos_z;
  logic [QW-1:0]     out_vel_x, out_vel_y, out_vel_z;
  logic              out_dynamic, out_grounded;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [QW-1:0]     cfg_data = '0;

  box_physics_step_core i_dut (.*);

  // Predictor state: axis-major tables, flags and configuration.
  int pos_m[3][NBOX];
  int vel_m[3][NBOX];
  int half_m[3][NBOX];
  bit dyn_m[NBOX];
  bit grnd_m[NBOX];
  int unsigned count_m;
  int gravity_m;

  box_cmd_t  pending_cmds[$];
  box_view_t expected_views[$];

  int errors = 0;
  int n_items = 0, n_reads = 0, n_steps = 0, n_cfg = 0;
  int cycle = 0;
  int calm_lo = 0, calm_hi = 0;   // window with no random idling
  int hold_req = 0;               // set by the sequence, consumed by the receiver
  int idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int clip(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  // Q16.16 product, rounded, floor shift, saturated.
  function automatic int qprod(int a, int b);
    longint p;
    p = longint'(a) * longint'(b) + 64'sd32768;
    return clip(p >>> 16);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Push one overlapping pair apart along axis ax by overlap o.
  task automatic separate(int ax, int i, int j, longint o);
    longint dir;
    longint h;
    int t;
    dir = pos_m[ax][i] >= pos_m[ax][j] ? 1 : -1;
    if (dyn_m[i] && dyn_m[j]) begin
      h = o >>> 1;
      pos_m[ax][i] = clip(longint'(pos_m[ax][i]) + dir * h);
      pos_m[ax][j] = clip(longint'(pos_m[ax][j]) - dir * h);
      t = vel_m[ax][i];
      vel_m[ax][i] = vel_m[ax][j];
      vel_m[ax][j] = t;
    end else if (dyn_m[i]) begin
      pos_m[ax][i] = clip(longint'(pos_m[ax][i]) + dir * o);
      if (ax != 1) begin
        vel_m[ax][i] = qprod(vel_m[ax][i], BOUNCE);
      end else if (dir > 0) begin
        if (vel_m[ax][i] < 0) vel_m[ax][i] = 0;
        grnd_m[i] = 1'b1;
      end else begin
        if (vel_m[ax][i] > 0) vel_m[ax][i] = 0;
      end
    end else begin
      pos_m[ax][j] = clip(longint'(pos_m[ax][j]) - dir * o);
      if (ax != 1) begin
        vel_m[ax][j] = qprod(vel_m[ax][j], BOUNCE);
      end else if (dir < 0) begin
        if (vel_m[ax][j] < 0) vel_m[ax][j] = 0;
        grnd_m[j] = 1'b1;
      end
    end
  endtask

  // One physics step: integrate, floor contact, then pairwise resolution.
  task automatic advance_world(int dt_raw);
    int n, dt, ax;
    longint ov[3];
    n = count_m > NBOX ? NBOX : int'(count_m);
    dt = dt_raw < 0 ? 0 : (dt_raw > DT_MAX ? DT_MAX : dt_raw);
    for (int i = 0; i < n; i++) begin
      if (!dyn_m[i]) begin
        grnd_m[i] = 1'b1;
        continue;
      end
      grnd_m[i] = 1'b0;
      vel_m[1][i] = clip(longint'(vel_m[1][i]) + qprod(gravity_m, dt));
      for (int a = 0; a < 3; a++)
        pos_m[a][i] = clip(longint'(pos_m[a][i]) + qprod(vel_m[a][i], dt));
      if (pos_m[1][i] <= clip(longint'(half_m[1][i]) + FLOOR_EPS)) begin
        pos_m[1][i] = half_m[1][i];
        if (vel_m[1][i] < 0) vel_m[1][i] = 0;
        grnd_m[i] = 1'b1;
        for (int a = 0; a < 3; a += 2) begin
          vel_m[a][i] = qprod(vel_m[a][i], FRICTION);
          if (mag(vel_m[a][i]) < REST_LIMIT) vel_m[a][i] = 0;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (!dyn_m[i] && !dyn_m[j]) continue;
        for (int a = 0; a < 3; a++)
          ov[a] = longint'(half_m[a][i]) + half_m[a][j]
                - mag(longint'(pos_m[a][i]) - pos_m[a][j]);
        if (ov[0] <= 0 || ov[1] <= 0 || ov[2] <= 0) continue;
        if (ov[0] < ov[1] && ov[0] < ov[2]) ax = 0;
        else if (ov[1] < ov[2]) ax = 1;
        else ax = 2;
        separate(ax, i, j, ov[ax]);
      end
    end
  endtask

  // Apply one accepted item to the predictor; queue the read-back it causes.
  task automatic apply_cmd(box_cmd_t c);
    box_view_t v;
    case (c.func)
      FN_WPOS: begin
        pos_m[0][c.idx] = c.vx; pos_m[1][c.idx] = c.vy; pos_m[2][c.idx] = c.vz;
        dyn_m[c.idx] = c.dyn;
      end
      FN_WVEL: begin
        vel_m[0][c.idx] = c.vx; vel_m[1][c.idx] = c.vy; vel_m[2][c.idx] = c.vz;
      end
      FN_WHALF: begin
        half_m[0][c.idx] = c.vx; half_m[1][c.idx] = c.vy; half_m[2][c.idx] = c.vz;
      end
      FN_STEP: begin
        advance_world(c.dt);
        n_steps++;
      end
      FN_READ: begin
        v.idx = c.idx;
        v.px = pos_m[0][c.idx]; v.py = pos_m[1][c.idx]; v.pz = pos_m[2][c.idx];
        v.vx = vel_m[0][c.idx]; v.vy = vel_m[1][c.idx]; v.vz = vel_m[2][c.idx];
        v.dyn = dyn_m[c.idx];
        v.grnd = grnd_m[c.idx];
        expected_views.push_back(v);
      end
      default: ;  // unused codes change nothing
    endcase
  endtask

  // Scene-scale values keep boxes near each other and the floor.
  function automatic box_cmd_t scene_cmd(logic [2:0] f, int idx);
    box_cmd_t c;
    bit noise;
    noise = $urandom_range(99) < 15;
    c.func = f;
    c.idx = 4'(idx);
    c.dyn = $urandom_range(99) < 75;
    c.dt = $urandom_range(99) < 75 ? $urandom_range(DT_MAX) : $urandom;
    case (f)
      FN_WPOS: begin
        c.vx = $signed($urandom_range(262144)) - 131072;
        c.vy = $urandom_range(196608);
        c.vz = $signed($urandom_range(262144)) - 131072;
      end
      FN_WVEL: begin
        c.vx = $signed($urandom_range(262144)) - 131072;
        c.vy = $signed($urandom_range(262144)) - 131072;
        c.vz = $signed($urandom_range(262144)) - 131072;
      end
      default: begin
        c.vx = $urandom_range(65536, 16384);
        c.vy = $urandom_range(65536, 16384);
        c.vz = $urandom_range(65536, 16384);
      end
    endcase
    if (noise) begin
      c.vx = $urandom; c.vy = $urandom; c.vz = $urandom;
    end
    return c;
  endfunction

  function automatic box_cmd_t random_cmd(int read_pct);
    int r;
    r = $urandom_range(99);
    if (r < read_pct) return scene_cmd(FN_READ, $urandom_range(NBOX - 1));
    if (r < read_pct + 15) return scene_cmd(FN_STEP, $urandom_range(NBOX - 1));
    if (r < 95) return scene_cmd(3'($urandom_range(2)), $urandom_range(NBOX - 1));
    return scene_cmd(3'($urandom_range(7, 5)), $urandom_range(NBOX - 1));
  endfunction

  // Sender: offer pending items, hold each until accepted.
  always @(posedge clk) begin
    box_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        c.func = in_func; c.idx = in_box_index;
        c.vx = in_vec_x; c.vy = in_vec_y; c.vz = in_vec_z;
        c.dyn = in_is_dynamic; c.dt = in_time_step;
        apply_cmd(c);
        n_items++;
      end
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() != 0 &&
            !(($urandom_range(99) < 26) && !(cycle >= calm_lo && cycle < calm_hi))) begin
          c = pending_cmds.pop_front();
          in_valid      <= 1'b1;
          in_func       <= c.func;
          in_box_index  <= c.idx;
          in_vec_x      <= c.vx;
          in_vec_y      <= c.vy;
          in_vec_z      <= c.vz;
          in_is_dynamic <= c.dyn;
          in_time_step  <= c.dt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off on request, field checks.
  int hold_left = 0;
  always @(posedge clk) begin
    box_view_t e;
    cycle <= cycle + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_reads++;
        if (expected_views.size() == 0) begin
          $error("read-back with nothing expected, index %0d", out_index);
          errors++;
        end else begin
          e = expected_views.pop_front();
          if (out_index !== e.idx) begin
            $error("out_index exp %0d got %0d", e.idx, out_index); errors++;
          end
          if (out_pos_x !== e.px) begin
            $error("pos_x exp %h got %h", e.px, out_pos_x); errors++;
          end
          if (out_pos_y !== e.py) begin
            $error("pos_y exp %h got %h", e.py, out_pos_y); errors++;
          end
          if (out_pos_z !== e.pz) begin
            $error("pos_z exp %h got %h", e.pz, out_pos_z); errors++;
          end
          if (out_vel_x !== e.vx) begin
            $error("vel_x exp %h got %h", e.vx, out_vel_x); errors++;
          end
          if (out_vel_y !== e.vy) begin
            $error("vel_y exp %h got %h", e.vy, out_vel_y); errors++;
          end
          if (out_vel_z !== e.vz) begin
            $error("vel_z exp %h got %h", e.vz, out_vel_z); errors++;
          end
          if (out_dynamic !== e.dyn) begin
            $error("out_dynamic exp %0d got %0d", e.dyn, out_dynamic); errors++;
          end
          if (out_grounded !== e.grnd) begin
            $error("out_grounded exp %0d got %0d", e.grnd, out_grounded); errors++;
          end
        end
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(($urandom_range(99) < 26) && !(cycle >= calm_lo && cycle < calm_hi));
      end
    end
  end

  // Watchdog: abort when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  // Write one register; call only while the core is idle.
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    if (idx == CFG_COUNT) count_m = 32'(data[4:0]);
    else gravity_m = data;
    n_cfg++;
  endtask

  // Wait until every item went in and every read-back came out, then let a step finish.
  task automatic drain();
    forever begin
      @(posedge clk);
      if (pending_cmds.size() == 0 && !in_valid && expected_views.size() == 0) break;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_phase(int n, int read_pct);
    repeat (n) pending_cmds.push_back(random_cmd(read_pct));
    drain();
  endtask

  initial begin
    box_cmd_t c;
    for (int i = 0; i < NBOX; i++) begin
      for (int a = 0; a < 3; a++) begin
        pos_m[a][i] = 0; vel_m[a][i] = 0; half_m[a][i] = 0;
      end
      dyn_m[i] = 1'b0; grnd_m[i] = 1'b0;
    end
    count_m = 0;
    gravity_m = GRAVITY_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_COUNT, 32'd16);
    // Load every entry once so that nothing undefined is ever read or stepped.
    for (int i = 0; i < NBOX; i++) begin
      pending_cmds.push_back(scene_cmd(FN_WPOS, i));
      pending_cmds.push_back(scene_cmd(FN_WVEL, i));
      pending_cmds.push_back(scene_cmd(FN_WHALF, i));
    end

    // Directed: extreme vectors, negative half extents, clamped time steps, unused codes.
    c = scene_cmd(FN_WPOS, 15);
    c.vx = 32'h7fffffff; c.vy = 32'h80000000; c.vz = 32'hffffffff; c.dyn = 1'b1;
    pending_cmds.push_back(c);
    c = scene_cmd(FN_WVEL, 15);
    c.vx = 32'h80000000; c.vy = 32'h7fffffff; c.vz = 32'h00000000;
    pending_cmds.push_back(c);
    c = scene_cmd(FN_WHALF, 14);
    c.vx = 32'hffff0000; c.vy = 32'h00008000; c.vz = 32'h80000000;
    pending_cmds.push_back(c);
    pending_cmds.push_back(scene_cmd(FN_READ, 15));
    pending_cmds.push_back(scene_cmd(FN_READ, 0));
    c = scene_cmd(FN_STEP, 0); c.dt = 32'h80000000; pending_cmds.push_back(c);
    c = scene_cmd(FN_STEP, 0); c.dt = 32'h7fffffff; pending_cmds.push_back(c);
    c = scene_cmd(FN_STEP, 0); c.dt = 32'd0;        pending_cmds.push_back(c);
    c = scene_cmd(FN_STEP, 0); c.dt = DT_MAX;       pending_cmds.push_back(c);
    pending_cmds.push_back(scene_cmd(FN_READ, 15));
    pending_cmds.push_back(scene_cmd(FN_READ, 14));
    for (int f = 5; f < 8; f++) pending_cmds.push_back(scene_cmd(3'(f), f));
    pending_cmds.push_back(scene_cmd(FN_READ, 5));
    drain();

    // Random phases across register settings, extremes included.
    random_phase(70, 35);
    write_reg(CFG_COUNT, 32'd0);
    random_phase(50, 35);
    write_reg(CFG_COUNT, 32'd31);         // above the table: limited to sixteen
    write_reg(CFG_GRAVITY, 32'h7fffffff);
    random_phase(60, 35);
    write_reg(CFG_GRAVITY, 32'h80000000);
    write_reg(CFG_COUNT, 32'd5);
    random_phase(60, 35);
    write_reg(CFG_GRAVITY, 32'd0);
    write_reg(CFG_COUNT, 32'd1);
    random_phase(50, 35);

    // Pressure: receiver holds off while reads keep coming.
    write_reg(CFG_GRAVITY, GRAVITY_RST);
    write_reg(CFG_COUNT, 32'd16);
    hold_req = HOLD_LONG;
    random_phase(60, 60);

    // Back-to-back stretch with no random idling.
    calm_lo = cycle;
    calm_hi = cycle + 8000;
    random_phase(80, 35);
    write_reg(CFG_COUNT, 32'd8);
    random_phase(70, 35);

    if (expected_views.size() != 0) begin
      $error("%0d read-backs never arrived", expected_views.size());
      errors++;
    end
    $display("Sent %0d items (%0d steps), checked %0d read-backs, %0d register writes",
             n_items, n_steps, n_reads, n_cfg);
    $display("Settings covered box counts 0 to 31 and gravity at both extremes");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
